### sv/ilpa_pkg.sv
// Package for the lease pool allocator: table size, action, status and register codes.
// Shared by the controller, the datapath and the top level.
package ilpa_pkg;

  localparam int unsigned TableEntries = 64;
  localparam int unsigned IdxW = $clog2(TableEntries);
  localparam int unsigned CntW = $clog2(TableEntries + 1);
  localparam int unsigned StepLimit = 2 * (TableEntries + 8);
  localparam int unsigned StepW = $clog2(StepLimit + 2);
  localparam logic [32:0] SecMax = 33'h1_FFFF_FFFF;

  typedef enum logic [2:0] {
    ActTick    = 3'd0,
    ActQuery   = 3'd1,
    ActAssign  = 3'd2,
    ActReserve = 3'd3,
    ActRelease = 3'd4,
    ActNext    = 3'd5,
    ActRsv6    = 3'd6,
    ActRsv7    = 3'd7
  } action_e;

  typedef enum logic [1:0] {
    StOk     = 2'd0,
    StInUse  = 2'd1,
    StNoFree = 2'd2,
    StFull   = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    EntExpired  = 2'd0,
    EntReserved = 2'd1,
    EntAssigned = 2'd2,
    EntUnused   = 2'd3
  } entry_state_e;

  typedef enum logic [2:0] {
    RegNet   = 3'd0,
    RegMask  = 3'd1,
    RegBcast = 3'd2,
    RegSrv   = 3'd3,
    RegLease = 3'd4,
    RegRsv   = 3'd5,
    RegExcl1 = 3'd6,
    RegExcl2 = 3'd7
  } reg_e;

  typedef enum logic [2:0] {
    CtlIdle,
    CtlScan,
    CtlEval,
    CtlWrite,
    CtlNextStep,
    CtlDone
  } ctl_state_e;

  // controller -> datapath
  typedef struct packed {
    logic load;       // capture input word
    logic scan_clr;   // restart table scan
    logic scan_adv;   // advance scan index
    logic commit;     // apply write / state update for the item
    logic next_adv;   // step next-free candidate
    logic finish;     // present result
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic scan_last;  // scan index reached entry count
    logic hit;        // entry found for the current address
    logic next_done;  // next-free search settled
  } dp_sts_t;

endpackage

### sv/ilpa_datapath.sv
// Datapath for the lease pool allocator: config registers, entry memory, scan,
// expiry evaluation and next-free stepping. Depends on ilpa_pkg.
module ilpa_datapath (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  input  logic [2:0]           cfg_index_i,
  input  logic [31:0]          cfg_data_i,
  input  logic [2:0]           action_i,
  input  logic [31:0]          ip_address_i,
  input  logic [47:0]          client_mac_i,
  input  ilpa_pkg::dp_cmd_t    cmd_i,
  output ilpa_pkg::dp_sts_t    sts_o,
  output logic [2:0]           action_o,
  output logic                 done_o,
  output logic [1:0]           status_code_o,
  output logic [31:0]          result_address_o,
  output logic [32:0]          lease_start_o,
  output logic                 free_flag_o,
  output logic                 reserved_flag_o,
  output logic                 assigned_flag_o
);

  logic [31:0] net_q, mask_q, bcast_q, srv_q, lease_q, rsv_q, ex1_q, ex2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      net_q <= '0; mask_q <= '0; bcast_q <= '0; srv_q <= '0;
      lease_q <= 32'd3600; rsv_q <= 32'd60; ex1_q <= '0; ex2_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (ilpa_pkg::reg_e'(cfg_index_i))
        ilpa_pkg::RegNet:   net_q <= cfg_data_i;
        ilpa_pkg::RegMask:  mask_q <= cfg_data_i;
        ilpa_pkg::RegBcast: bcast_q <= cfg_data_i;
        ilpa_pkg::RegSrv:   srv_q <= cfg_data_i;
        ilpa_pkg::RegLease: lease_q <= cfg_data_i;
        ilpa_pkg::RegRsv:   rsv_q <= cfg_data_i;
        ilpa_pkg::RegExcl1: ex1_q <= cfg_data_i;
        ilpa_pkg::RegExcl2: ex2_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Entry memory, one row per lease; rows below count_q are valid.
  logic [31:0] mem_addr [ilpa_pkg::TableEntries];
  logic [47:0] mem_mac  [ilpa_pkg::TableEntries];
  logic [32:0] mem_stamp[ilpa_pkg::TableEntries];
  logic [1:0]  mem_state[ilpa_pkg::TableEntries];

  logic [ilpa_pkg::CntW-1:0]  count_q, count_d;
  logic [ilpa_pkg::CntW-1:0]  scan_q;
  logic [31:0] sptr_q, sptr_d;
  logic [32:0] sec_q, sec_d;
  logic [2:0]  act_q;
  logic [31:0] addr_q, cur_q;
  logic [47:0] mac_q;
  logic        hit_q;
  logic [ilpa_pkg::IdxW-1:0] hit_idx_q;
  logic [31:0] rd_addr_q;
  logic [47:0] rd_mac_q;
  logic [32:0] rd_stamp_q;
  logic [1:0]  rd_state_q;
  logic        wrapped_q;
  logic [ilpa_pkg::StepW-1:0] steps_q;
  logic        next_done_q, found_q;

  logic [ilpa_pkg::IdxW-1:0] scan_idx;
  assign scan_idx = scan_q[ilpa_pkg::IdxW-1:0];

  logic        scan_last;
  assign scan_last = (scan_q == count_q);

  // Register the address of the row at the scan index, with that index.
  logic        rd_vld_q;
  logic [ilpa_pkg::IdxW-1:0] rd_idx_q;
  always_ff @(posedge clk_i) begin
    rd_addr_q <= mem_addr[scan_idx];
    rd_idx_q  <= scan_idx;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) rd_vld_q <= 1'b0;
    else         rd_vld_q <= cmd_i.scan_adv && !scan_last;
  end

  // Live state of the hit entry (read registered at hit time).
  logic [33:0] lease_end, rsv_end;
  logic [1:0]  live;
  always_comb begin
    lease_end = {1'b0, rd_stamp_q} + {2'b00, lease_q};
    rsv_end   = {1'b0, rd_stamp_q} + {2'b00, rsv_q};
    live = rd_state_q;
    if (rd_state_q != ilpa_pkg::EntReserved && rd_state_q != ilpa_pkg::EntAssigned)
      live = ilpa_pkg::EntExpired;
    else if (lease_end < {1'b0, sec_q})
      live = ilpa_pkg::EntExpired;
    else if (rd_state_q == ilpa_pkg::EntReserved && rsv_end < {1'b0, sec_q})
      live = ilpa_pkg::EntExpired;
    if (!hit_q) live = ilpa_pkg::EntExpired;
  end

  function automatic logic in_net(input logic [31:0] a, input logic [31:0] n,
                                  input logic [31:0] m, input logic [31:0] b);
    in_net = (a != n) && (a != b) && ((a & m) == n);
  endfunction

  logic [31:0] tgt;
  assign tgt = (act_q == ilpa_pkg::ActNext) ? cur_q : addr_q;

  logic excl, free_now, held_r, held_a;
  always_comb begin
    excl = (tgt == srv_q) || (ex1_q != '0 && tgt == ex1_q) || (ex2_q != '0 && tgt == ex2_q);
    free_now = in_net(tgt, net_q, mask_q, bcast_q) && !excl && (live == ilpa_pkg::EntExpired);
    held_r = (live == ilpa_pkg::EntReserved) && (rd_mac_q == mac_q);
    held_a = (live == ilpa_pkg::EntAssigned) && (rd_mac_q == mac_q);
  end

  // next-free candidate step
  logic [31:0] nxt;
  assign nxt = cur_q + 32'd1;

  logic [1:0]  status_d;
  logic [32:0] start_d;
  logic [31:0] res_d;
  logic        ff_d, fr_d, fa_d;
  logic        we;
  logic [ilpa_pkg::IdxW-1:0] widx;
  logic [1:0]  wstate;
  logic        wfull;
  logic        rel;

  always_comb begin
    status_d = ilpa_pkg::StOk;
    start_d  = '0;
    res_d    = addr_q;
    ff_d = 1'b0; fr_d = 1'b0; fa_d = 1'b0;
    we = 1'b0; widx = hit_idx_q; wstate = ilpa_pkg::EntAssigned; wfull = 1'b0;
    rel = 1'b0;
    count_d = count_q;
    sptr_d = sptr_q;
    sec_d = sec_q;
    if (!hit_q) widx = count_q[ilpa_pkg::IdxW-1:0];
    wfull = !hit_q && (count_q == ilpa_pkg::CntW'(ilpa_pkg::TableEntries));
    unique case (ilpa_pkg::action_e'(act_q))
      ilpa_pkg::ActTick: if (sec_q < ilpa_pkg::SecMax) sec_d = sec_q + 33'd1;
      ilpa_pkg::ActQuery: begin
        ff_d = free_now; fr_d = held_r; fa_d = held_a;
      end
      ilpa_pkg::ActAssign: begin
        if (held_r || held_a || free_now) begin
          if (wfull && !(held_r || held_a)) status_d = ilpa_pkg::StFull;
          else begin
            we = 1'b1; start_d = sec_q;
            if (!hit_q) count_d = count_q + 1'b1;
          end
        end else status_d = ilpa_pkg::StInUse;
      end
      ilpa_pkg::ActReserve: begin
        wstate = ilpa_pkg::EntReserved;
        if (wfull) status_d = ilpa_pkg::StFull;
        else begin
          we = 1'b1;
          if (!hit_q) count_d = count_q + 1'b1;
        end
      end
      ilpa_pkg::ActRelease: rel = hit_q;
      ilpa_pkg::ActNext: begin
        sptr_d = cur_q;
        if (found_q) res_d = cur_q;
        else status_d = ilpa_pkg::StNoFree;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit && we) begin
      mem_addr[widx]  <= addr_q;
      mem_mac[widx]   <= (held_r || held_a) ? rd_mac_q : mac_q;
      mem_stamp[widx] <= sec_q;
      mem_state[widx] <= wstate;
    end else if (cmd_i.commit && rel) begin
      mem_state[widx] <= ilpa_pkg::EntExpired;
    end
    if (cmd_i.load) begin
      act_q <= action_i; addr_q <= ip_address_i; mac_q <= client_mac_i;
    end
    if (rd_vld_q && rd_addr_q == tgt && !hit_q) begin
      hit_idx_q <= rd_idx_q;
      rd_mac_q  <= mem_mac[rd_idx_q];
      rd_stamp_q <= mem_stamp[rd_idx_q];
      rd_state_q <= mem_state[rd_idx_q];
    end
    if (cmd_i.finish) begin
      status_code_o <= status_d; result_address_o <= res_d; lease_start_o <= start_d;
      free_flag_o <= ff_d; reserved_flag_o <= fr_d; assigned_flag_o <= fa_d;
    end
  end

  // Control state of the datapath.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0; sptr_q <= '0; sec_q <= '0; scan_q <= '0; hit_q <= 1'b0;
      cur_q <= '0; wrapped_q <= 1'b0; steps_q <= '0; next_done_q <= 1'b0;
      found_q <= 1'b0; done_o <= 1'b0;
    end else begin
      done_o <= cmd_i.finish;
      if (cmd_i.load) begin
        cur_q <= sptr_q; wrapped_q <= 1'b0; steps_q <= '0;
        next_done_q <= 1'b0; found_q <= 1'b0;
      end
      if (cmd_i.scan_clr) begin
        scan_q <= '0; hit_q <= 1'b0;
      end else if (cmd_i.scan_adv && !scan_last) begin
        scan_q <= scan_q + 1'b1;
      end
      if (rd_vld_q && rd_addr_q == tgt) hit_q <= 1'b1;
      if (cmd_i.next_adv) begin
        // evaluate the candidate whose scan has just finished
        if (free_now) begin
          found_q <= 1'b0 | 1'b1; next_done_q <= 1'b1;
        end else if (steps_q == ilpa_pkg::StepW'(ilpa_pkg::StepLimit)) begin
          next_done_q <= 1'b1;
        end else begin
          steps_q <= steps_q + 1'b1;
          if (!in_net(nxt, net_q, mask_q, bcast_q)) begin
            // second exit: stop on the address that left the subnet
            if (wrapped_q) begin
              cur_q <= nxt; next_done_q <= 1'b1;
            end else begin
              wrapped_q <= 1'b1; cur_q <= net_q + 32'd1;
            end
          end else cur_q <= nxt;
        end
      end
      if (cmd_i.commit) begin
        count_q <= count_d; sptr_q <= sptr_d; sec_q <= sec_d;
      end
    end
  end

  assign sts_o.scan_last = scan_last && !rd_vld_q;
  assign sts_o.hit       = hit_q;
  assign sts_o.next_done = next_done_q;
  assign action_o        = act_q;

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= ilpa_pkg::CntW'(ilpa_pkg::TableEntries))
    else $error("entry count beyond table size");
  a_done_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe held");
  a_sec_mono: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sec_q >= $past(sec_q))
    else $error("seconds counter went back");
`endif

endmodule

### sv/ilpa_ctrl.sv
// Controller state machine for the lease pool allocator.
// Sequences scan, evaluate, write and next-free steps. Depends on ilpa_pkg.
module ilpa_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [2:0]         action_i,
  input  ilpa_pkg::dp_sts_t  sts_i,
  output ilpa_pkg::dp_cmd_t  cmd_o,
  output logic               busy_o
);

  ilpa_pkg::ctl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ilpa_pkg::CtlIdle;
    else         state_q <= state_d;
  end

  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    busy_o = (state_q != ilpa_pkg::CtlIdle);
    unique case (state_q)
      ilpa_pkg::CtlIdle: if (start_i) begin
        cmd_o.load = 1'b1; cmd_o.scan_clr = 1'b1;
        state_d = ilpa_pkg::CtlScan;
      end
      ilpa_pkg::CtlScan: begin
        cmd_o.scan_adv = 1'b1;
        if (sts_i.scan_last) state_d = ilpa_pkg::CtlEval;
      end
      ilpa_pkg::CtlEval: begin
        if (action_i == ilpa_pkg::ActNext) begin
          cmd_o.next_adv = 1'b1;
          state_d = ilpa_pkg::CtlNextStep;
        end else state_d = ilpa_pkg::CtlWrite;
      end
      ilpa_pkg::CtlNextStep: begin
        if (sts_i.next_done) state_d = ilpa_pkg::CtlWrite;
        else begin
          cmd_o.scan_clr = 1'b1;
          state_d = ilpa_pkg::CtlScan;
        end
      end
      ilpa_pkg::CtlWrite: begin
        cmd_o.finish = 1'b1;
        state_d = ilpa_pkg::CtlDone;
      end
      ilpa_pkg::CtlDone: begin
        cmd_o.commit = 1'b1;
        state_d = ilpa_pkg::CtlIdle;
      end
      default: state_d = ilpa_pkg::CtlIdle;
    endcase
  end

`ifndef SYNTH
  a_one_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.finish, cmd_o.commit, cmd_o.next_adv}))
    else $error("conflicting commands");
  a_commit_after: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.finish |=> cmd_o.commit)
    else $error("commit did not follow result");
  a_load_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |-> !busy_o)
    else $error("load while busy");
`endif

endmodule

### sv/ip_lease_pool_allocator.sv
// Top level of the lease pool allocator: joins controller and datapath.
// Depends on ilpa_pkg, ilpa_ctrl and ilpa_datapath.
//
// Usage: hold start with action_i, ip_address_i and client_mac_i; the word
// is taken at a clock edge with start high and busy low. One result word
// follows, shown for a single cycle with done_o high; it cannot be held off.
// Sequence: a plain action scans the table, evaluates, presents the result
// on done_o and commits its write; busy falls after the commit. Next-free
// rescans the table for every candidate, up to 145 candidates, before the
// result. Items are handled one at a time.
// Registers are written on cfg_valid_i with cfg_index_i/cfg_data_i; cfg_ready_o
// is always high. Writes must be made only while busy is low; the block
// itself does not enforce this.
// Reset clears the table count, search pointer, seconds counter and control;
// table rows are not cleared, only rows below the count are ever read.
module ip_lease_pool_allocator (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  action_i,
  input  logic [31:0] ip_address_i,
  input  logic [47:0] client_mac_i,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  output logic        done_o,
  output logic [1:0]  status_code_o,
  output logic [31:0] result_address_o,
  output logic [32:0] lease_start_o,
  output logic        free_flag_o,
  output logic        reserved_flag_o,
  output logic        assigned_flag_o
);

  ilpa_pkg::dp_cmd_t cmd;
  ilpa_pkg::dp_sts_t sts;
  logic [2:0] act;

  assign cfg_ready_o = 1'b1;

  ilpa_ctrl u_ctrl (
    .clk_i, .rst_ni, .start_i(start), .action_i(act), .sts_i(sts),
    .cmd_o(cmd), .busy_o(busy)
  );

  ilpa_datapath u_dp (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_index_i, .cfg_data_i,
    .action_i, .ip_address_i, .client_mac_i, .cmd_i(cmd), .sts_o(sts),
    .action_o(act), .done_o, .status_code_o, .result_address_o, .lease_start_o,
    .free_flag_o, .reserved_flag_o, .assigned_flag_o
  );

endmodule
